>>> rtl/imhq_pkg.sv
package imhq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DEC  = 3'd2,
    OP_INC  = 3'd3,
    OP_CLR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POS_WAIT,
    S_CHECK,
    S_LAST_WAIT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_HEAD_RD,
    S_DONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic rd_pos;
    logic rd_last;
    logic load_last;
    logic rd_parent;
    logic rd_children;
    logic move_parent;
    logic move_child;
    logic place;
    logic size_inc;
    logic size_dec;
    logic size_clr;
    logic set_key;
    logic rd_head;
    logic [1:0] status;
    logic done;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic empty;
    logic full;
    logic id_ok;
    logic present;
    logic at_root;
    logic up_go;
    logic has_child;
    logic dn_go;
    logic size_one;
  } sts_t;

endpackage

>>> rtl/indexed_min_heap_queue.sv
// Indexed binary min-heap of (id, key) entries. Raise start_i with opcode_i,
// elem_id_i and new_key_i while busy_o is low; the request is taken at that
// edge and busy_o stays high until the single result appears on the result
// ports for one cycle with done_o high. The receiver cannot stall, so the
// result must be captured in that cycle. Clear, a pop on an empty or one-entry
// heap and a dropped push go straight to the head read; a key change on an
// absent id ends after the slot lookup of its id. Otherwise each heap level
// crossed takes one registered read of the parent or both children, then one
// compare and move, and a key change first looks up the slot of its id.
// busy_o falls in the cycle after the result, so a new request can only be
// taken once the last one is through.
// Pop from an empty heap reports underflow, push into a full heap is
// dropped with overflow status; key changes for absent ids do nothing.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int ID_COUNT  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  elem_id_i,
  input  logic [31:0] new_key_i,
  output logic        done_o,
  output logic        head_valid_o,
  output logic [7:0]  head_id_o,
  output logic [31:0] head_key_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o,
  output logic [1:0]  status_o
);

  cmd_t cmd;
  sts_t sts;

  imhq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  imhq_dp #(
    .CAPACITY (CAPACITY),
    .ID_COUNT (ID_COUNT),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (opcode_i),
    .elem_id_i    (elem_id_i),
    .new_key_i    (new_key_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .head_valid_o (head_valid_o),
    .head_id_o    (head_id_o),
    .head_key_o   (head_key_o),
    .entry_count_o(entry_count_o),
    .status_o     (status_o),
    .done_o       (done_o)
  );

endmodule

>>> rtl/imhq_ctrl.sv
module imhq_ctrl
  import imhq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        case (sts_i.op)
          OP_PUSH: state_d = (sts_i.full || !sts_i.id_ok) ? S_HEAD_RD : S_UP_RD;
          OP_POP: begin
            if (sts_i.empty) state_d = S_HEAD_RD;
            else if (sts_i.size_one) state_d = S_HEAD_RD;
            else state_d = S_LAST_WAIT;
          end
          OP_DEC, OP_INC: state_d = sts_i.id_ok ? S_POS_WAIT : S_HEAD_RD;
          default: state_d = S_HEAD_RD;
        endcase
      end
      S_POS_WAIT: state_d = S_CHECK;
      S_CHECK: begin
        if (!sts_i.present) state_d = S_HEAD_RD;
        else if (sts_i.op == OP_DEC) state_d = S_UP_RD;
        else state_d = S_DN_RD;
      end
      S_LAST_WAIT: state_d = S_DN_RD;
      S_UP_RD: state_d = sts_i.at_root ? S_PLACE : S_UP_CMP;
      S_UP_CMP: state_d = sts_i.up_go ? S_UP_RD : S_PLACE;
      S_DN_RD: state_d = sts_i.has_child ? S_DN_CMP : S_PLACE;
      S_DN_CMP: state_d = sts_i.dn_go ? S_DN_RD : S_PLACE;
      S_PLACE: state_d = S_HEAD_RD;
      S_HEAD_RD: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: cmd_o.load_req = start_i;
      S_DECODE: begin
        case (sts_i.op)
          OP_PUSH: begin
            if (sts_i.full) cmd_o.status = ST_OVERFLOW;
            else if (sts_i.id_ok) cmd_o.size_inc = 1'b1;
          end
          OP_POP: begin
            if (sts_i.empty) cmd_o.status = ST_UNDERFLOW;
            else begin
              cmd_o.size_dec = 1'b1;
              cmd_o.rd_last = 1'b1;
            end
          end
          OP_CLR: cmd_o.size_clr = 1'b1;
          default: ;
        endcase
      end
      S_POS_WAIT: cmd_o.rd_pos = 1'b1;
      S_CHECK: cmd_o.set_key = sts_i.present;
      S_LAST_WAIT: cmd_o.load_last = 1'b1;
      S_UP_RD: cmd_o.rd_parent = !sts_i.at_root;
      S_UP_CMP: cmd_o.move_parent = sts_i.up_go;
      S_DN_RD: cmd_o.rd_children = sts_i.has_child;
      S_DN_CMP: cmd_o.move_child = sts_i.dn_go;
      S_PLACE: cmd_o.place = 1'b1;
      S_HEAD_RD: cmd_o.rd_head = 1'b1;
      S_DONE: cmd_o.done = 1'b1;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_DECODE)
    else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.done |=> state_q == S_IDLE)
    else $error("done not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.size_inc, cmd_o.size_dec, cmd_o.size_clr}))
    else $error("conflicting size updates");

endmodule

>>> rtl/imhq_dp.sv
module imhq_dp
  import imhq_pkg::*;
#(
  parameter int CAPACITY  = 256,
  parameter int ID_COUNT  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [2:0]                   opcode_i,
  input  logic [7:0]                   elem_id_i,
  input  logic [31:0]                  new_key_i,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  output logic                         head_valid_o,
  output logic [7:0]                   head_id_o,
  output logic [31:0]                  head_key_o,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count_o,
  output logic [1:0]                   status_o,
  output logic                         done_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(ID_COUNT);
  localparam int KW = KEY_WIDTH;
  localparam int CKW = (KW < 32) ? KW : 32;

  // heap storage: id and key per slot, plus id to slot map
  logic [IW-1:0] ids_mem [CAPACITY];
  logic [KW-1:0] keys_mem [CAPACITY];
  logic [SW-1:0] pos_mem [ID_COUNT];

  logic [CW-1:0] size_q;
  logic [2:0]    op_q;
  logic [7:0]    rid_q;
  logic [KW-1:0] rkey_q;
  logic [SW:0]   slot_q;
  logic [IW-1:0] mid_q;
  logic [KW-1:0] mkey_q;
  logic [1:0]    status_q;
  // registered read ports
  logic [IW-1:0] rda_id_q, rdb_id_q;
  logic [KW-1:0] rda_key_q, rdb_key_q;
  logic [SW-1:0] pos_rd_q;
  logic [SW:0]   rda_slot_q;

  logic [KW-1:0] key_in;
  assign key_in = KW'(new_key_i);

  // status and entry count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= '0;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.load_req) status_q <= ST_OK;
      if (cmd_i.status != ST_OK) status_q <= cmd_i.status;
      if (cmd_i.size_inc) size_q <= size_q + CW'(1);
      if (cmd_i.size_dec) size_q <= size_q - CW'(1);
      if (cmd_i.size_clr) size_q <= '0;
    end
  end

  logic [SW:0] parent, lchild, rchild, sel_child;
  logic        right_ok, pick_right;
  assign parent  = (slot_q - (SW+1)'(1)) >> 1;
  assign lchild  = {slot_q[SW-1:0], 1'b1};
  assign rchild  = lchild + (SW+1)'(1);
  assign right_ok = ((SW+2)'(rchild) < (SW+2)'(size_q));
  assign pick_right = right_ok && (rda_key_q > rdb_key_q);
  assign sel_child = pick_right ? rchild : lchild;

  // request capture, moving entry and its slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q   <= opcode_i;
      rid_q  <= elem_id_i;
      rkey_q <= key_in;
    end
    if (cmd_i.size_inc) begin
      slot_q <= (SW+1)'(size_q);
      mid_q  <= IW'(rid_q);
      mkey_q <= rkey_q;
    end
    if (cmd_i.load_last) begin
      slot_q <= '0;
      mid_q  <= rda_id_q;
      mkey_q <= rda_key_q;
    end
    if (cmd_i.set_key) begin
      slot_q <= (SW+1)'(pos_rd_q);
      mid_q  <= IW'(rid_q);
      mkey_q <= rkey_q;
    end
    if (cmd_i.move_parent) slot_q <= rda_slot_q;
    if (cmd_i.move_child)  slot_q <= sel_child;
  end

  // read address selection, port a and port b
  // the present check reads the id held at the mapped slot through port a
  logic [SW-1:0] addr_a, addr_b;
  always_comb begin
    addr_a = '0;
    addr_b = SW'(rchild);
    if (cmd_i.rd_last)     addr_a = SW'(size_q - CW'(1));
    if (cmd_i.rd_pos)      addr_a = pos_rd_q;
    if (cmd_i.rd_parent)   addr_a = SW'(parent);
    if (cmd_i.rd_children) addr_a = SW'(lchild);
    if (cmd_i.rd_head)     addr_a = '0;
  end

  // memory writes and registered reads
  logic          wr_en;
  logic [SW-1:0] wr_slot;
  logic [IW-1:0] wr_id;
  always_comb begin
    wr_en   = 1'b0;
    wr_slot = SW'(slot_q);
    wr_id   = mid_q;
    if (cmd_i.move_parent) begin
      wr_en = 1'b1; wr_id = rda_id_q;
    end else if (cmd_i.move_child) begin
      wr_en = 1'b1;
      wr_id = pick_right ? rdb_id_q : rda_id_q;
    end else if (cmd_i.place) begin
      wr_en = 1'b1;
    end
  end

  logic [KW-1:0] wr_key;
  always_comb begin
    wr_key = mkey_q;
    if (cmd_i.move_parent) wr_key = rda_key_q;
    if (cmd_i.move_child)  wr_key = pick_right ? rdb_key_q : rda_key_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ids_mem[wr_slot]  <= wr_id;
      keys_mem[wr_slot] <= wr_key;
      pos_mem[wr_id]    <= wr_slot;
    end
    rda_id_q   <= ids_mem[addr_a];
    rda_key_q  <= keys_mem[addr_a];
    rdb_id_q   <= ids_mem[addr_b];
    rdb_key_q  <= keys_mem[addr_b];
    rda_slot_q <= cmd_i.rd_parent ? parent : (SW+1)'(addr_a);
    pos_rd_q   <= pos_mem[IW'(rid_q)];
  end

  // status toward the controller
  always_comb begin
    sts_o.op        = op_q;
    sts_o.empty     = (size_q == '0);
    sts_o.full      = ((CW+1)'(size_q) >= (CW+1)'(CAPACITY));
    sts_o.id_ok     = (32'(rid_q) < 32'(ID_COUNT));
    sts_o.present   = ((CW+1)'(pos_rd_q) < (CW+1)'(size_q)) && (rda_id_q == IW'(rid_q));
    sts_o.at_root   = (slot_q == '0);
    sts_o.up_go     = (mkey_q <= rda_key_q);
    sts_o.has_child = ((SW+2)'(lchild) < (SW+2)'(size_q));
    sts_o.dn_go     = mkey_q > (pick_right ? rdb_key_q : rda_key_q);
    sts_o.size_one  = (size_q == CW'(1));
  end

  // result outputs
  assign head_valid_o  = (size_q != '0);
  assign head_id_o     = head_valid_o ? 8'(rda_id_q) : 8'd0;
  assign head_key_o    = head_valid_o ? 32'(rda_key_q[CKW-1:0]) : 32'd0;
  assign entry_count_o = size_q;
  assign status_o      = status_q;
  assign done_o        = cmd_i.done;

endmodule

>>> tb/indexed_min_heap_queue_test.sv
`timescale 1ns / 1ps

module indexed_min_heap_queue_test
  import imhq_pkg::*;
;

  localparam int CAP = 256;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  opcode_i;
  logic [7:0]  elem_id_i;
  logic [31:0] new_key_i;
  logic        done_o;
  logic        head_valid_o;
  logic [7:0]  head_id_o;
  logic [31:0] head_key_o;
  logic [8:0]  entry_count_o;
  logic [1:0]  status_o;

  typedef struct packed {
    logic        head_valid;
    logic [7:0]  head_id;
    logic [31:0] head_key;
    logic [8:0]  entry_count;
    logic [1:0]  status;
  } head_rpt_t;

  // shadow heap
  logic [7:0]  shadow_ids [CAP];
  logic [31:0] shadow_keys [CAP];
  logic [8:0]  shadow_pos [256];
  bit          id_written [256];
  int unsigned shadow_size;

  head_rpt_t pending_rpts [$];
  int        fail_count;

  indexed_min_heap_queue u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .opcode_i(opcode_i), .elem_id_i(elem_id_i), .new_key_i(new_key_i),
    .done_o(done_o), .head_valid_o(head_valid_o), .head_id_o(head_id_o),
    .head_key_o(head_key_o), .entry_count_o(entry_count_o), .status_o(status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void shadow_place(int unsigned slot, logic [7:0] id, logic [31:0] key);
    shadow_ids[slot] = id;
    shadow_keys[slot] = key;
    shadow_pos[id] = slot[8:0];
    id_written[id] = 1'b1;
  endfunction

  function automatic void shadow_up(int unsigned slot);
    logic [7:0]  id;
    logic [31:0] key;
    int unsigned up;
    id = shadow_ids[slot];
    key = shadow_keys[slot];
    while (slot > 0) begin
      up = (slot - 1) / 2;
      if (key <= shadow_keys[up]) begin
        shadow_place(slot, shadow_ids[up], shadow_keys[up]);
        slot = up;
      end else break;
    end
    shadow_place(slot, id, key);
  endfunction

  function automatic void shadow_down(int unsigned slot);
    logic [7:0]  id;
    logic [31:0] key;
    int unsigned child;
    id = shadow_ids[slot];
    key = shadow_keys[slot];
    child = slot * 2 + 1;
    while (child < shadow_size) begin
      if (child + 1 < shadow_size && shadow_keys[child] > shadow_keys[child + 1]) child++;
      if (key > shadow_keys[child]) begin
        shadow_place(slot, shadow_ids[child], shadow_keys[child]);
        slot = child;
      end else break;
      child = slot * 2 + 1;
    end
    shadow_place(slot, id, key);
  endfunction

  // apply one request to the shadow heap and return the head report
  function automatic head_rpt_t heap_apply(logic [2:0] op, logic [7:0] id, logic [31:0] key);
    head_rpt_t   r;
    int unsigned slot;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_size >= CAP) r.status = ST_OVERFLOW;
        else begin
          slot = shadow_size;
          shadow_place(slot, id, key);
          shadow_size++;
          shadow_up(slot);
        end
      end
      OP_POP: begin
        if (shadow_size == 0) r.status = ST_UNDERFLOW;
        else begin
          shadow_size--;
          shadow_place(0, shadow_ids[shadow_size], shadow_keys[shadow_size]);
          if (shadow_size > 0) shadow_down(0);
        end
      end
      OP_DEC, OP_INC: begin
        if (id_written[id]) begin
          slot = shadow_pos[id];
          if (slot < shadow_size && shadow_ids[slot] == id) begin
            shadow_keys[slot] = key;
            if (op == OP_DEC) shadow_up(slot);
            else shadow_down(slot);
          end
        end
      end
      OP_CLR: shadow_size = 0;
      default: ;
    endcase
    r.head_valid = (shadow_size > 0);
    r.head_id = r.head_valid ? shadow_ids[0] : 8'd0;
    r.head_key = r.head_valid ? shadow_keys[0] : 32'd0;
    r.entry_count = shadow_size[8:0];
    return r;
  endfunction

  // a key change on an id whose map entry was never written would read an undefined slot
  function automatic bit key_change_safe(logic [7:0] id);
    return id_written[id];
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // send one request and queue its expected report
  task automatic send_request(logic [2:0] op, logic [7:0] id, logic [31:0] key);
    int unsigned g;
    if ((op == OP_DEC || op == OP_INC) && !key_change_safe(id)) op = OP_POP;
    g = gap_len();
    // idle gap with scrambled payload
    if (g != 0) begin
      start_i <= 1'b0;
      opcode_i <= 3'($urandom());
      elem_id_i <= 8'($urandom());
      new_key_i <= $urandom();
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    elem_id_i <= id;
    new_key_i <= key;
    pending_rpts.push_back(heap_apply(op, id, key));
    // hold the request through the edge that takes it, then wait while busy_o is high
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain_reports();
    start_i <= 1'b0;
    while (pending_rpts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    head_rpt_t e;
    if (rst_ni && done_o) begin
      if (pending_rpts.size() == 0) begin
        $error("report with no request pending");
        fail_count++;
      end else begin
        e = pending_rpts.pop_front();
        if (head_valid_o !== e.head_valid) begin
          $error("head_valid exp %0d got %0d", e.head_valid, head_valid_o); fail_count++;
        end
        if (head_id_o !== e.head_id) begin
          $error("head_id exp %0d got %0d", e.head_id, head_id_o); fail_count++;
        end
        if (head_key_o !== e.head_key) begin
          $error("head_key exp %0h got %0h", e.head_key, head_key_o); fail_count++;
        end
        if (entry_count_o !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, entry_count_o); fail_count++;
        end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(OP_POP, 8'd0, 32'd0);
    send_request(OP_DEC, 8'd5, 32'd1);
    send_request(OP_PUSH, 8'd0, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 8'd255, 32'd0);
    send_request(OP_PUSH, 8'd7, 32'd0);
    send_request(OP_PUSH, 8'd8, 32'd100);
    send_request(OP_PUSH, 8'd8, 32'd50);
    send_request(OP_DEC, 8'd0, 32'd0);
    send_request(OP_INC, 8'd7, 32'hFFFF_FFFF);
    send_request(OP_DEC, 8'd255, 32'hFFFF_FFFF);
    send_request(OP_INC, 8'd0, 32'd0);
    send_request(3'd5, 8'd1, 32'd1);
    send_request(3'd6, 8'd1, 32'd1);
    send_request(3'd7, 8'd1, 32'd1);
    send_request(OP_POP, 8'd0, 32'd0);
    send_request(OP_POP, 8'd0, 32'd0);
    send_request(OP_CLR, 8'd0, 32'd0);
    send_request(OP_POP, 8'd0, 32'd0);
    send_request(OP_DEC, 8'd7, 32'd3);
    drain_reports();
  endtask

  // fill to capacity, overflow, decrease ten keys, then empty in order and underflow
  task automatic test_full_heap();
    for (int i = 0; i < CAP; i++) send_request(OP_PUSH, i[7:0], $urandom_range(0, 63));
    send_request(OP_PUSH, 8'd9, 32'd0);
    send_request(OP_PUSH, 8'd10, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) send_request(OP_DEC, 8'($urandom()), $urandom_range(0, 63));
    for (int i = 0; i < CAP + 1; i++) send_request(OP_POP, 8'd0, 32'd0);
    drain_reports();
  endtask

  task automatic test_random_mix();
    int unsigned sel;
    logic [31:0] k;
    for (int i = 0; i < 500; i++) begin
      sel = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 31);
      if (sel < 40) send_request(OP_PUSH, 8'($urandom()), k);
      else if (sel < 62) send_request(OP_POP, 8'($urandom()), $urandom());
      else if (sel < 78) send_request(OP_DEC, 8'($urandom()), k);
      else if (sel < 94) send_request(OP_INC, 8'($urandom()), k);
      else if (sel < 97) send_request(OP_CLR, 8'($urandom()), $urandom());
      else send_request(3'($urandom_range(5, 7)), 8'($urandom()), $urandom());
      if (i == 250) drain_reports();
    end
    drain_reports();
  endtask

  initial begin
    fail_count = 0;
    shadow_size = 0;
    foreach (id_written[i]) id_written[i] = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = '0;
    elem_id_i = '0;
    new_key_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_heap();
    test_random_mix();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> indexed_min_heap_queue.f
rtl/imhq_pkg.sv
rtl/imhq_ctrl.sv
rtl/imhq_dp.sv
rtl/indexed_min_heap_queue.sv
tb/indexed_min_heap_queue_test.sv
